// ===== hdl/pscp_pkg.sv =====
// ----------------------------------------------------------------------------
// pscp_pkg: shared types and constants of the movement credit policer
// Beat layouts, configuration set, row record, engine states, register codes.
// ----------------------------------------------------------------------------
package pscp_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int QDEPTH    = 2;
	localparam int ITER_N    = 17;
	localparam int DIV_K     = 125;
	localparam int DIV_SH    = 35;

	localparam logic [28:0] DIV_RECIP = 29'h1062_4DD3;

	localparam logic [2:0] REG_MAX_SPEED  = 3'd0;
	localparam logic [2:0] REG_JUMP_CAP   = 3'd1;
	localparam logic [2:0] REG_MAX_DEBT   = 3'd2;
	localparam logic [2:0] REG_BANK_MAX   = 3'd3;
	localparam logic [2:0] REG_REBASE_GAP = 3'd4;

	localparam logic [15:0] RST_MAX_SPEED  = 16'd10000;
	localparam logic [15:0] RST_JUMP_CAP   = 16'd50;
	localparam logic [23:0] RST_MAX_DEBT   = 24'd30000;
	localparam logic [15:0] RST_BANK_MAX   = 16'd5000;
	localparam logic [31:0] RST_REBASE_GAP = 32'd10000;

	typedef struct packed {
		logic [2:0]         slot;
		logic [31:0]        occupant_gen;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               pos_invalid;
		logic [23:0]        sender_stamp;
		logic [31:0]        now_ms;
	} pose_t;

	typedef struct packed {
		logic               anchored;
		logic               unstamped_edge;
		logic               invalid_edge;
		logic               discontinuity_edge;
		logic               trusted_now;
		logic [31:0]        step_dist;
		logic signed [31:0] credit_out;
		logic [23:0]        dt_sender_ms;
		logic [31:0]        dt_recv_ms;
		logic [15:0]        use_ms;
	} verdict_t;

	typedef struct packed {
		logic [15:0] max_speed_cm_s;
		logic [15:0] jump_cap_cm;
		logic [23:0] max_debt_cm;
		logic [15:0] bank_max_ms;
		logic [31:0] rebase_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic        vld;
		pose_t       item;
	} fq_t;

	typedef struct packed {
		logic [31:0]        gen;
		logic               armed;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] credit;
		logic               trusted;
		logic [23:0]        prev_stamp;
		logic [31:0]        prev_recv;
		logic [15:0]        bank;
		logic               useen;
		logic               iseen;
		logic               dseen;
	} row_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_SUM,
		ST_ITER,
		ST_FIN
	} bk_state_t;

endpackage

// ===== hdl/pscp_front.sv =====
// ----------------------------------------------------------------------------
// pscp_front: pose intake queue
// Accepts pose beats, drops slots outside the row table, buffers the rest.
// ----------------------------------------------------------------------------
module pscp_front #(
	parameter int SLOTS = pscp_pkg::SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  pscp_pkg::pose_t pose,
	input  logic            take,
	output pscp_pkg::fq_t   fq
);
	import pscp_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int NW = $clog2(QDEPTH + 1);

	pose_t           ent_q [QDEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [NW-1:0]   cnt_q;
	logic            in_range;
	logic            wr;

	assign full     = (cnt_q == NW'(QDEPTH));
	assign in_range = ({29'd0, pose.slot} < 32'(SLOTS));
	assign wr       = push && !full && in_range;
	assign fq.vld   = (cnt_q != '0);
	assign fq.item  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= PW'(wp_q + 1'b1);
			if (take)
				rp_q <= PW'(rp_q + 1'b1);
			if (wr && !take)
				cnt_q <= NW'(cnt_q + 1'b1);
			else if (!wr && take)
				cnt_q <= NW'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			ent_q[wp_q] <= pose;
	end

endmodule

// ===== hdl/pscp_back.sv =====
// ----------------------------------------------------------------------------
// pscp_back: policing engine
// Row table, interval and bank update, squared step, iterative square root,
// reciprocal credit divider, credit update and result register.
// ----------------------------------------------------------------------------
module pscp_back #(
	parameter int SLOTS = pscp_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pscp_pkg::cfg_t     cfg,
	input  pscp_pkg::fq_t      fq,
	output logic               take,
	input  logic               pop,
	output logic               empty,
	output pscp_pkg::verdict_t verdict
);
	import pscp_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(ITER_N);

	bk_state_t   st_q, st_d;
	logic [CW-1:0] cnt_q;

	pose_t       item_q;
	row_t        mem_q [SLOTS];
	logic [SLOTS-1:0] vld_q;
	row_t        rd_q;
	logic        rd_vld_q;

	row_t        row_q;
	logic        anchor_q, stamped_q;
	logic [15:0] use_q, bank_q;
	logic [23:0] dts_q;
	logic [31:0] dtr_q;
	logic [31:0] dx_q, dy_q, dz_q;
	logic [63:0] sqx_q, sqy_q, sqz_q;
	logic [31:0] prod_q;
	logic        sat_q;
	logic [67:0] rad_q;
	logic [35:0] rem_q;
	logic [33:0] root_q;
	logic [25:0] qd_q;
	logic [33:0] quo_q;

	verdict_t    res_q;
	logic        res_vld_q;

	row_t        row_rd;
	logic        anchor_c, stamped_c, gap_c;
	logic [31:0] dtr_c;
	logic [32:0] bsum_c;
	logic [15:0] bcap_c, use_c, bank_c, use_raw;
	logic [23:0] dts_c, dts_raw;

	logic [65:0] sum_c;

	logic [35:0] rem_n;
	logic [33:0] root_n;

	logic [60:0] mq_c;
	logic [31:0] dr_c;
	logic        rnd_c;

	logic [31:0] step_c;
	logic signed [39:0] cap_c, flo_c, carry_c, cred_c;
	logic        trusted_c, disc_c, fin_go;
	row_t        row_w;
	verdict_t    out_c;

	function automatic logic [31:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [32:0] d;
		logic [32:0]        m;
		d = {a[31], a} - {b[31], b};
		m = d[32] ? 33'(-d) : 33'(d);
		return m[31:0];
	endfunction

	assign take   = (st_q == ST_IDLE) && fq.vld;
	assign fin_go = (st_q == ST_FIN) && (!res_vld_q || pop);
	assign empty  = !res_vld_q;
	assign verdict = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cnt_q     <= '0;
			vld_q     <= '0;
			res_vld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_SUM)
				cnt_q <= '0;
			else if (st_q == ST_ITER)
				cnt_q <= CW'(cnt_q + 1'b1);
			if (fin_go)
				vld_q[IW'(item_q.slot)] <= 1'b1;
			if (fin_go)
				res_vld_q <= 1'b1;
			else if (pop)
				res_vld_q <= 1'b0;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (fq.vld) st_d = ST_READ;
			ST_READ: st_d = ST_MUL;
			ST_MUL:  st_d = ST_SUM;
			ST_SUM:  st_d = ST_ITER;
			ST_ITER: if (cnt_q == CW'(ITER_N - 1)) st_d = ST_FIN;
			ST_FIN:  if (fin_go) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fin_go)
			mem_q[IW'(item_q.slot)] <= row_w;
		if (take) begin
			item_q   <= fq.item;
			rd_q     <= mem_q[IW'(fq.item.slot)];
			rd_vld_q <= vld_q[IW'(fq.item.slot)];
		end
	end

	always_comb begin
		row_rd    = rd_vld_q ? rd_q : '0;
		anchor_c  = !row_rd.armed || (row_rd.gen != item_q.occupant_gen);
		stamped_c = (item_q.sender_stamp != '0);
		dtr_c     = item_q.now_ms - row_rd.prev_recv;
		gap_c     = (dtr_c >= cfg.rebase_gap_ms);
		bsum_c    = 33'(row_rd.bank) + 33'(dtr_c);
		bcap_c    = (bsum_c > 33'(cfg.bank_max_ms)) ? cfg.bank_max_ms : bsum_c[15:0];
		dts_raw   = item_q.sender_stamp - row_rd.prev_stamp;
		use_raw   = (dts_raw < {8'd0, bcap_c}) ? dts_raw[15:0] : bcap_c;
		if (!stamped_c) begin
			use_c  = '0;
			dts_c  = '0;
			bank_c = row_rd.bank;
		end else if (gap_c) begin
			use_c  = '0;
			dts_c  = '0;
			bank_c = '0;
		end else begin
			use_c  = use_raw;
			dts_c  = dts_raw;
			bank_c = 16'(bcap_c - use_raw);
		end
	end

	assign sum_c = 66'(sqx_q) + 66'(sqy_q) + 66'(sqz_q);

	assign mq_c  = 61'(prod_q) * 61'(DIV_RECIP);
	assign dr_c  = prod_q - 32'(32'(qd_q) * 32'(DIV_K));
	assign rnd_c = ({dr_c[30:0], 1'b0} >= 32'(DIV_K));

	always_comb begin
		logic [35:0] r;
		logic [33:0] t;
		logic [37:0] rr, tr;
		r = rem_q;
		t = root_q;
		for (int k = 0; k < 2; k++) begin
			rr = {r, rad_q[67-2*k -: 2]};
			tr = 38'({t, 2'b01});
			if (rr >= tr) begin
				r = 36'(rr - tr);
				t = {t[32:0], 1'b1};
			end else begin
				r = 36'(rr);
				t = {t[32:0], 1'b0};
			end
		end
		rem_n  = r;
		root_n = t;
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_READ: begin
				row_q     <= row_rd;
				anchor_q  <= anchor_c;
				stamped_q <= stamped_c;
				use_q     <= use_c;
				bank_q    <= bank_c;
				dts_q     <= dts_c;
				dtr_q     <= dtr_c;
				dx_q      <= abs_diff(item_q.pos_x, row_rd.ax);
				dy_q      <= abs_diff(item_q.pos_y, row_rd.ay);
				dz_q      <= abs_diff(item_q.pos_z, row_rd.az);
			end
			ST_MUL: begin
				sqx_q  <= 64'(dx_q) * 64'(dx_q);
				sqy_q  <= 64'(dy_q) * 64'(dy_q);
				sqz_q  <= 64'(dz_q) * 64'(dz_q);
				prod_q <= 32'(cfg.max_speed_cm_s) * 32'(use_q);
			end
			ST_SUM: begin
				sat_q  <= |sum_c[65:64];
				rad_q  <= {4'd0, sum_c[63:0]};
				rem_q  <= '0;
				root_q <= '0;
				qd_q   <= 26'(mq_c >> DIV_SH);
			end
			ST_ITER: begin
				rad_q  <= {rad_q[63:0], 4'd0};
				rem_q  <= rem_n;
				root_q <= root_n;
				quo_q  <= {7'd0, qd_q, rnd_c};
			end
			default: ;
		endcase
	end

	always_comb begin
		step_c  = sat_q ? '1 : root_q[31:0];
		cap_c   = 40'({cfg.jump_cap_cm, 4'd0});
		flo_c   = -40'({cfg.max_debt_cm, 4'd0});
		carry_c = 40'(row_q.credit);
		if (carry_c > cap_c)
			carry_c = cap_c;
		cred_c = carry_c + 40'(quo_q) - 40'(step_c);
		if (cred_c > cap_c)
			cred_c = cap_c;
		if (cred_c < flo_c)
			cred_c = flo_c;
		trusted_c = stamped_q && !cred_c[39];
		disc_c    = row_q.trusted && !trusted_c && !row_q.dseen;

		row_w = row_q;
		out_c = '0;
		if (item_q.pos_invalid) begin
			row_w.trusted      = 1'b0;
			row_w.iseen        = 1'b1;
			out_c.invalid_edge = !row_q.iseen;
			out_c.credit_out   = row_q.credit;
		end else if (anchor_q) begin
			row_w.gen        = item_q.occupant_gen;
			row_w.armed      = 1'b1;
			row_w.ax         = item_q.pos_x;
			row_w.ay         = item_q.pos_y;
			row_w.az         = item_q.pos_z;
			row_w.credit     = '0;
			row_w.trusted    = 1'b1;
			row_w.prev_stamp = item_q.sender_stamp;
			row_w.prev_recv  = item_q.now_ms;
			row_w.bank       = '0;
			row_w.useen      = 1'b0;
			row_w.iseen      = 1'b0;
			row_w.dseen      = 1'b0;
			out_c.anchored    = 1'b1;
			out_c.trusted_now = 1'b1;
		end else begin
			row_w.ax        = item_q.pos_x;
			row_w.ay        = item_q.pos_y;
			row_w.az        = item_q.pos_z;
			row_w.credit    = cred_c[31:0];
			row_w.trusted   = trusted_c;
			row_w.prev_recv = item_q.now_ms;
			row_w.bank      = bank_q;
			if (stamped_q)
				row_w.prev_stamp = item_q.sender_stamp;
			row_w.useen = row_q.useen || !stamped_q;
			row_w.dseen = row_q.dseen || disc_c;
			out_c.unstamped_edge     = !stamped_q && !row_q.useen;
			out_c.discontinuity_edge = disc_c;
			out_c.trusted_now        = trusted_c;
			out_c.step_dist          = step_c;
			out_c.credit_out         = cred_c[31:0];
			out_c.dt_sender_ms       = dts_q;
			out_c.dt_recv_ms         = dtr_q;
			out_c.use_ms             = use_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go)
			res_q <= out_c;
	end

endmodule

// ===== hdl/per_slot_movement_credit_policer.sv =====
// ----------------------------------------------------------------------------
// per_slot_movement_credit_policer: distance credit policer for peer poses
//
// Input channel: pose beats enter on push while full is low. Slots at or
// above SLOTS are taken and dropped without a result.
// Result channel: one verdict beat per kept pose, shown while empty is low
// and taken on pop.
// Configuration: wr_en/wr_idx/wr_data write one register per cycle.
// The engine works on one pose at a time: an iterative square root forms
// two root bits per cycle, and the earned credit quotient comes from a
// reciprocal multiply alongside it.
// A two-entry intake queue takes poses while the engine works; a finished
// verdict waiting on pop holds the engine, and push sees full once the
// queue fills.
// Reset clears the row table valid bits, the queues and the registers to
// their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_slot_movement_credit_policer #(
	parameter int SLOTS = pscp_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pscp_pkg::pose_t    pose,
	output logic               empty,
	input  logic               pop,
	output pscp_pkg::verdict_t verdict,
	input  logic               wr_en,
	input  logic [2:0]         wr_idx,
	input  logic [31:0]        wr_data
);
	import pscp_pkg::*;

	cfg_t cfg_q;
	fq_t  fq;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed_cm_s <= RST_MAX_SPEED;
			cfg_q.jump_cap_cm    <= RST_JUMP_CAP;
			cfg_q.max_debt_cm    <= RST_MAX_DEBT;
			cfg_q.bank_max_ms    <= RST_BANK_MAX;
			cfg_q.rebase_gap_ms  <= RST_REBASE_GAP;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_MAX_SPEED:  cfg_q.max_speed_cm_s <= wr_data[15:0];
				REG_JUMP_CAP:   cfg_q.jump_cap_cm    <= wr_data[15:0];
				REG_MAX_DEBT:   cfg_q.max_debt_cm    <= wr_data[23:0];
				REG_BANK_MAX:   cfg_q.bank_max_ms    <= wr_data[15:0];
				REG_REBASE_GAP: cfg_q.rebase_gap_ms  <= wr_data;
				default: ;
			endcase
		end
	end

	pscp_front #(.SLOTS(SLOTS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.pose   (pose),
		.take   (take),
		.fq     (fq)
	);

	pscp_back #(.SLOTS(SLOTS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.fq      (fq),
		.take    (take),
		.pop     (pop),
		.empty   (empty),
		.verdict (verdict)
	);

endmodule

// ===== hdl/pscp_chk.sv =====
// ----------------------------------------------------------------------------
// pscp_chk: port checker for the movement credit policer
// Watches the result channel for beat stability and verdict consistency.
// ----------------------------------------------------------------------------
module pscp_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input pscp_pkg::verdict_t verdict
);
	import pscp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(verdict))
		else $error("result beat changed while stalled");

	a_anchor: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && verdict.anchored |-> verdict.trusted_now && verdict.step_dist == '0
			&& verdict.credit_out == '0 && verdict.use_ms == '0)
		else $error("anchor beat carries nonzero fields");

	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && verdict.invalid_edge |-> !verdict.anchored && !verdict.trusted_now)
		else $error("invalid beat marked anchored or trusted");

	a_trust: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && verdict.trusted_now |-> !verdict.credit_out[31])
		else $error("trusted verdict with debt");

endmodule

bind per_slot_movement_credit_policer pscp_chk u_chk (.*);

// ===== tb/pscp_checker.sv =====
// ----------------------------------------------------------------------------
// pscp_checker: verdict predictor and scoreboard for the credit policer
// Watches the pose and verdict channels and the register write port. Each
// accepted pose is run through a behavioral copy of the row table, and each
// accepted verdict is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pscp_checker #(
	parameter int SLOTS = pscp_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  pscp_pkg::pose_t    pose,
	input  logic               empty,
	input  logic               pop,
	input  pscp_pkg::verdict_t verdict,
	input  logic               wr_en,
	input  logic [2:0]         wr_idx,
	input  logic [31:0]        wr_data,
	output int                 n_fail,
	output int                 n_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pscp_pkg::*;

	cfg_t     cfg;
	row_t     rows [SLOTS];
	verdict_t verdict_q [$];

	assign n_pending = verdict_q.size();

	function automatic logic [63:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return (d < 0) ? -d : d;
	endfunction

	function automatic logic [31:0] root64(logic [63:0] n);
		logic [63:0] r, bit_v;
		r = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (n >= r + bit_v) begin
				n = n - (r + bit_v);
				r = (r >> 1) + bit_v;
			end else begin
				r = r >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return r[31:0];
	endfunction

	function automatic logic [31:0] step_len(row_t rw, pose_t p);
		logic [63:0] d [3];
		logic [64:0] acc;
		d[0] = abs_diff(rw.ax, p.pos_x);
		d[1] = abs_diff(rw.ay, p.pos_y);
		d[2] = abs_diff(rw.az, p.pos_z);
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			if (d[i] > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
			acc = acc + d[i] * d[i];
			if (acc[64]) return 32'hFFFF_FFFF;
		end
		return root64(acc[63:0]);
	endfunction

	function automatic verdict_t police_pose(pose_t p);
		verdict_t v;
		row_t rw;
		logic stamped, was_trusted;
		logic [31:0] dt_r;
		logic [23:0] dt_s;
		logic [63:0] bank, use_v;
		longint cap, floor_v, carry, earned, credit;
		v = '0;
		rw = rows[p.slot];
		if (p.pos_invalid) begin
			rw.trusted = 1'b0;
			if (!rw.iseen) begin
				rw.iseen = 1'b1;
				v.invalid_edge = 1'b1;
			end
			v.credit_out = rw.credit;
			rows[p.slot] = rw;
			return v;
		end
		if (!rw.armed || rw.gen != p.occupant_gen) begin
			rw = '0;
			rw.gen = p.occupant_gen;
			rw.armed = 1'b1;
			rw.ax = p.pos_x;
			rw.ay = p.pos_y;
			rw.az = p.pos_z;
			rw.trusted = 1'b1;
			rw.prev_stamp = p.sender_stamp;
			rw.prev_recv = p.now_ms;
			rows[p.slot] = rw;
			v.anchored = 1'b1;
			v.trusted_now = 1'b1;
			return v;
		end
		stamped = (p.sender_stamp != 0);
		if (!stamped && !rw.useen) begin
			rw.useen = 1'b1;
			v.unstamped_edge = 1'b1;
		end
		dt_r = p.now_ms - rw.prev_recv;
		dt_s = 0;
		use_v = 0;
		if (stamped) begin
			if (dt_r >= cfg.rebase_gap_ms) begin
				rw.bank = 0;
			end else begin
				bank = 64'(rw.bank) + dt_r;
				dt_s = p.sender_stamp - rw.prev_stamp;
				if (bank > cfg.bank_max_ms) bank = cfg.bank_max_ms;
				use_v = (dt_s < bank) ? 64'(dt_s) : bank;
				rw.bank = 16'(bank - use_v);
			end
		end
		v.step_dist = step_len(rw, p);
		cap = longint'(cfg.jump_cap_cm) * 16;
		floor_v = -(longint'(cfg.max_debt_cm) * 16);
		carry = longint'(rw.credit);
		if (carry > cap) carry = cap;
		earned = longint'((64'(cfg.max_speed_cm_s) * use_v * 16) / 1000);
		credit = carry + earned - longint'(v.step_dist);
		if (credit > cap) credit = cap;
		if (credit < floor_v) credit = floor_v;
		was_trusted = rw.trusted;
		rw.credit = 32'(credit);
		rw.trusted = stamped && credit >= 0;
		rw.ax = p.pos_x;
		rw.ay = p.pos_y;
		rw.az = p.pos_z;
		if (stamped) rw.prev_stamp = p.sender_stamp;
		rw.prev_recv = p.now_ms;
		if (was_trusted && !rw.trusted && !rw.dseen) begin
			rw.dseen = 1'b1;
			v.discontinuity_edge = 1'b1;
		end
		rows[p.slot] = rw;
		v.trusted_now = rw.trusted;
		v.credit_out = 32'(credit);
		v.dt_sender_ms = dt_s;
		v.dt_recv_ms = dt_r;
		v.use_ms = 16'(use_v);
		return v;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			n_fail++;
			$display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	initial n_fail = 0;

	always @(posedge clk or negedge arst_n) begin
		verdict_t e;
		if (!arst_n) begin
			cfg.max_speed_cm_s <= RST_MAX_SPEED;
			cfg.jump_cap_cm <= RST_JUMP_CAP;
			cfg.max_debt_cm <= RST_MAX_DEBT;
			cfg.bank_max_ms <= RST_BANK_MAX;
			cfg.rebase_gap_ms <= RST_REBASE_GAP;
			for (int i = 0; i < SLOTS; i++) rows[i] = '0;
			verdict_q.delete();
		end else begin
			if (wr_en) begin
				case (wr_idx)
					REG_MAX_SPEED: cfg.max_speed_cm_s <= wr_data[15:0];
					REG_JUMP_CAP: cfg.jump_cap_cm <= wr_data[15:0];
					REG_MAX_DEBT: cfg.max_debt_cm <= wr_data[23:0];
					REG_BANK_MAX: cfg.bank_max_ms <= wr_data[15:0];
					REG_REBASE_GAP: cfg.rebase_gap_ms <= wr_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (verdict_q.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected verdict beat expected none actual %h",
						$time, verdict);
				end else begin
					e = verdict_q.pop_front();
					check_field("anchored", e.anchored, verdict.anchored);
					check_field("unstamped_edge", e.unstamped_edge, verdict.unstamped_edge);
					check_field("invalid_edge", e.invalid_edge, verdict.invalid_edge);
					check_field("discontinuity_edge", e.discontinuity_edge,
						verdict.discontinuity_edge);
					check_field("trusted_now", e.trusted_now, verdict.trusted_now);
					check_field("step_dist", e.step_dist, verdict.step_dist);
					check_field("credit_out", e.credit_out, verdict.credit_out);
					check_field("dt_sender_ms", e.dt_sender_ms, verdict.dt_sender_ms);
					check_field("dt_recv_ms", e.dt_recv_ms, verdict.dt_recv_ms);
					check_field("use_ms", e.use_ms, verdict.use_ms);
				end
			end
			if (push && !full && pose.slot < SLOTS) verdict_q.push_back(police_pose(pose));
		end
	end

endmodule

// ===== tb/tb_per_slot_movement_credit_policer.sv =====
// ----------------------------------------------------------------------------
// tb_per_slot_movement_credit_policer: top of the credit policer testbench
// Drives directed and random pose beats in bursts, stalls the verdict side,
// steps through several register settings while idle, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_per_slot_movement_credit_policer;
	timeunit 1ns;
	timeprecision 1ps;
	import pscp_pkg::*;

	localparam int POSE_W = $bits(pose_t);

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	pose_t       pose;
	logic        empty;
	logic        pop;
	verdict_t    verdict;
	logic        wr_en;
	logic [2:0]  wr_idx;
	logic [31:0] wr_data;
	int          n_fail;
	int          n_pending;
	int          hold_off;
	bit          stalls_on;

	pose_t       track [8];
	logic [31:0] clock_ms;

	per_slot_movement_credit_policer u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pose(pose),
		.empty(empty), .pop(pop), .verdict(verdict),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
	);

	pscp_checker u_chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pose(pose),
		.empty(empty), .pop(pop), .verdict(verdict),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
		.n_fail(n_fail), .n_pending(n_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("per_slot_movement_credit_policer test failed");
		$finish;
	end

	initial begin
		pop = 1'b0;
		hold_off = 0;
		@(negedge arst_n);
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				hold_off--;
				pop <= 1'b0;
			end else if (stalls_on) begin
				pop <= ($urandom_range(0, 3) != 0);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic send_beat(pose_t p);
		push <= 1'b1;
		pose <= p;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic go_quiet();
		push <= 1'b0;
		pose <= pose_t'(POSE_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom}));
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		int n;
		go_quiet();
		n = 0;
		while (n_pending != 0 && n < 200000) begin
			@(negedge clk);
			n++;
		end
		repeat (60) @(negedge clk);
	endtask

	function automatic logic [31:0] rnd_coord(logic [31:0] base);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3, 4: return base + $urandom_range(0, 4000) - 2000;
			default: return base + $urandom_range(0, 200) - 100;
		endcase
	endfunction

	function automatic pose_t next_pose(int s);
		pose_t p;
		int k;
		p = track[s];
		k = $urandom_range(0, 99);
		p.slot = 3'(s);
		if (k < 4) p.occupant_gen = $urandom;
		p.pos_x = rnd_coord(p.pos_x);
		p.pos_y = rnd_coord(p.pos_y);
		p.pos_z = rnd_coord(p.pos_z);
		p.pos_invalid = ($urandom_range(0, 29) == 0);
		clock_ms = clock_ms + (($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 300));
		p.now_ms = clock_ms;
		if ($urandom_range(0, 14) == 0) p.sender_stamp = 0;
		else if ($urandom_range(0, 19) == 0) p.sender_stamp = 24'($urandom);
		else p.sender_stamp = 24'(track[s].sender_stamp + $urandom_range(0, 400));
		if (!p.pos_invalid && p.sender_stamp != 0) track[s] = p;
		return p;
	endfunction

	task automatic random_phase(int count);
		pose_t p;
		int left, burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				if ($urandom_range(0, 19) == 0) begin
					p = pose_t'(POSE_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom}));
				end else begin
					p = next_pose($urandom_range(0, 7));
				end
				send_beat(p);
				burst--;
				left--;
			end
			if ($urandom_range(0, 2) != 0) begin
				go_quiet();
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
		end
	endtask

	task automatic directed_phase();
		pose_t p;
		p = '0;
		p.slot = 3'd1;
		p.pos_invalid = 1'b1;
		send_beat(p);
		send_beat(p);
		p.pos_invalid = 1'b0;
		p.occupant_gen = 32'hFFFF_FFFF;
		p.sender_stamp = 24'd100;
		p.now_ms = 32'hFFFF_FF00;
		send_beat(p);
		p.sender_stamp = 24'd150;
		p.now_ms = 32'h0000_0010;
		p.pos_x = 32'sd400;
		send_beat(p);
		p.sender_stamp = 24'd0;
		p.now_ms = 32'h20;
		send_beat(p);
		send_beat(p);
		p.sender_stamp = 24'hFFFF_FF;
		p.now_ms = 32'h7000_0000;
		send_beat(p);
		p.sender_stamp = 24'd5;
		p.now_ms = 32'h7000_0050;
		p.pos_x = 32'h7FFF_FFFF;
		p.pos_y = 32'h8000_0000;
		p.pos_z = 32'h7FFF_FFFF;
		send_beat(p);
		p.pos_x = 32'h8000_0000;
		p.pos_y = 32'h7FFF_FFFF;
		p.pos_z = 32'h8000_0000;
		p.sender_stamp = 24'd50;
		p.now_ms = 32'h7000_0080;
		send_beat(p);
		p.pos_invalid = 1'b1;
		send_beat(p);
		send_beat(p);
		p.pos_invalid = 1'b0;
		p.occupant_gen = 32'd7;
		send_beat(p);
		p.slot = 3'd7;
		p.occupant_gen = 32'd0;
		send_beat(p);
		p.sender_stamp = 24'd60;
		p.now_ms = p.now_ms + 32'd10;
		send_beat(p);
		p.slot = 3'd0;
		send_beat(p);
		p.now_ms = p.now_ms + 32'd3000;
		p.sender_stamp = 24'd4000;
		send_beat(p);
	endtask

	initial begin
		arst_n = 1'b1;
		push = 1'b0;
		pose = '0;
		wr_en = 1'b0;
		wr_idx = REG_MAX_SPEED;
		wr_data = '0;
		stalls_on = 1'b0;
		clock_ms = '0;
		for (int i = 0; i < 8; i++) track[i] = '0;
		#1 arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_phase();
		drain();

		stalls_on = 1'b1;
		random_phase(300);
		hold_off = 400;
		random_phase(40);
		drain();

		write_reg(REG_MAX_SPEED, 32'hFFFF);
		write_reg(REG_JUMP_CAP, 32'hFFFF);
		write_reg(REG_MAX_DEBT, 32'hFF_FFFF);
		write_reg(REG_BANK_MAX, 32'hFFFF);
		write_reg(REG_REBASE_GAP, 32'hFFFF_FFFF);
		write_reg(3'd6, $urandom);
		random_phase(300);
		drain();

		write_reg(REG_MAX_SPEED, 32'd0);
		write_reg(REG_JUMP_CAP, 32'd0);
		write_reg(REG_MAX_DEBT, 32'd0);
		write_reg(REG_BANK_MAX, 32'd0);
		write_reg(REG_REBASE_GAP, 32'd0);
		stalls_on = 1'b0;
		random_phase(200);
		drain();

		write_reg(REG_MAX_SPEED, $urandom_range(1000, 20000));
		write_reg(REG_JUMP_CAP, $urandom_range(10, 500));
		write_reg(REG_MAX_DEBT, $urandom);
		write_reg(REG_BANK_MAX, $urandom_range(100, 8000));
		write_reg(REG_REBASE_GAP, $urandom_range(200, 20000));
		stalls_on = 1'b1;
		random_phase(460);
		drain();

		if (n_fail == 0 && n_pending == 0) begin
			$display("per_slot_movement_credit_policer test passed");
		end else begin
			$display("per_slot_movement_credit_policer test failed");
		end
		$finish;
	end

endmodule
